// ===== sv/kbd_pkg.sv =====
// Shared types, constants and helpers for the kinematic bicycle derivative core.
`default_nettype none
package kbd_pkg;

    localparam int ANG_W  = 28;   // CORDIC angle, Q.24
    localparam int CRD_W  = 34;   // CORDIC x/y, Q2.30 with headroom
    localparam int PRD_W  = 50;   // speed * trig product
    localparam int DPR_W  = 48;   // wheelbase * cos product
    localparam int NUM_W  = 63;   // rounded dividend 2n + d
    localparam int DEN_W  = 49;   // doubled divisor 2d
    localparam int QUO_W  = 25;   // quotient bits below the overflow check
    localparam int DIV_STAGES = QUO_W + 1;
    localparam int CMP_W  = DEN_W + QUO_W;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [23:0] YAW_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] YAW_MIN = 24'sh800000;
    localparam logic [QUO_W-1:0]   Q_LIM_POS = 25'd8388607;
    localparam logic [QUO_W-1:0]   Q_LIM_NEG = 25'd8388608;

    // Sideband through the CORDIC stages
    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] accel;
        logic signed [15:0] srate;
    } t_side_a;

    // Sideband through the divider stages
    typedef struct packed {
        logic signed [15:0] x_rate;
        logic signed [15:0] y_rate;
        logic signed [15:0] accel;
        logic signed [15:0] srate;
        logic               qneg;
        logic               nzero;
        logic               dzero;
        logic               nneg;
    } t_side_b;

    function automatic logic signed [ANG_W-1:0] atan_of(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            8:  r = 28'sd65536;
            9:  r = 28'sd32768;
            10: r = 28'sd16384;
            11: r = 28'sd8192;
            12: r = 28'sd4096;
            13: r = 28'sd2048;
            14: r = 28'sd1024;
            15: r = 28'sd512;
            16: r = 28'sd256;
            17: r = 28'sd128;
            18: r = 28'sd64;
            19: r = 28'sd32;
            20: r = 28'sd16;
            21: r = 28'sd8;
            22: r = 28'sd4;
            23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // (p + 2^29) >>> 30, clamped to 16 bits
    function automatic logic signed [15:0] rate_round(input logic signed [PRD_W-1:0] p);
        logic signed [PRD_W:0] s;
        logic signed [20:0]    t;
        logic signed [15:0]    r;
        s = (PRD_W+1)'(p) + 51'sd536870912;
        t = 21'(s >>> 30);
        if (t > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (t < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/kbd_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine in Q2.30.
`default_nettype none
module kbd_cordic
    import kbd_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic [STEPS+1:0]        i_en,
    input  wire logic signed [15:0]      i_ang,
    output logic signed [CRD_W-1:0]      o_sin,
    output logic signed [CRD_W-1:0]      o_cos
);

    logic signed [CRD_W-1:0] r_x [0:STEPS];
    logic signed [CRD_W-1:0] r_y [0:STEPS];
    logic signed [ANG_W-1:0] r_z [0:STEPS];
    logic                    r_neg [0:STEPS];
    logic signed [CRD_W-1:0] r_sin, r_cos;

    logic signed [ANG_W-1:0] n_z0, z_in;
    logic                    n_neg0;

    // fold by pi into [-pi/2, pi/2]
    always_comb begin
        z_in = ANG_W'(i_ang) <<< 11;
        n_z0 = z_in;
        n_neg0 = 1'b0;
        if (z_in > ANG_HALF_PI) begin
            n_z0 = z_in - ANG_PI;
            n_neg0 = 1'b1;
        end else if (z_in < -ANG_HALF_PI) begin
            n_z0 = z_in + ANG_PI;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_of(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_of(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[STEPS+1]) begin
            r_cos <= r_neg[STEPS] ? -r_x[STEPS] : r_x[STEPS];
            r_sin <= r_neg[STEPS] ? -r_y[STEPS] : r_y[STEPS];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// ===== sv/kbd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
`default_nettype none
module kbd_div
    import kbd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [DIV_STAGES-1:0]   i_en,
    input  wire logic [NUM_W-1:0]        i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic [QUO_W-1:0]             o_quot,
    output logic                         o_ovf
);

    logic [NUM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= CMP_W'(i_num) >= {i_den, {QUO_W{1'b0}}};
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_bit
        localparam int K = QUO_W - j;
        logic [CMP_W-1:0] sh;
        logic             ge;
        assign sh = CMP_W'(r_den[j-1]) << K;
        assign ge = CMP_W'(r_rem[j-1]) >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_rem[j] <= ge ? r_rem[j-1] - sh[NUM_W-1:0] : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (ge ? (QUO_W'(1) << K) : '0);
            end
        end
    end

    assign o_quot = r_q[QUO_W];
    assign o_ovf  = r_ovf[QUO_W];

endmodule
`default_nettype wire

// ===== sv/kinematic_bicycle_derivative_core.sv =====
// Top level: kinematic bicycle model derivative, fully pipelined.
// Throughput: one transaction per cycle; every stage has its own valid bit and
//   holds when the stage after it is full and stalled, so bubbles collapse.
// Depth is set by the CORDIC iterations and the 26-stage restoring divider.
// Reset (synchronous, active low) clears all valid bits and sets wheelbase to 2.5 m.
`default_nettype none
module kinematic_bicycle_derivative_core
    import kbd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [12:0]        i_cfg_data,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_heading_angle,
    input  wire logic signed [15:0] i_speed,
    input  wire logic signed [14:0] i_steer_angle,
    input  wire logic signed [15:0] i_accel_cmd,
    input  wire logic signed [15:0] i_steer_rate_cmd,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_x_rate,
    output logic signed [15:0]      o_y_rate,
    output logic signed [23:0]      o_yaw_rate,
    output logic signed [15:0]      o_speed_rate,
    output logic signed [15:0]      o_steer_rate,
    output logic                    o_saturated
);

    // stage map
    localparam int CE = CORDIC_STEPS + 1;       // last CORDIC stage
    localparam int M1 = CORDIC_STEPS + 2;       // products
    localparam int M2 = CORDIC_STEPS + 3;       // magnitudes, rate rounding
    localparam int D0 = CORDIC_STEPS + 4;       // first divider stage
    localparam int DL = D0 + DIV_STAGES - 1;    // last divider stage
    localparam int NS = DL + 2;                 // stage count, output is NS-1

    logic [12:0]    r_wheelbase;
    logic [NS-1:0]  r_v;
    logic [NS-1:0]  en;

    // A stage loads whenever it is empty or the stage after it moves.
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_wheelbase <= 13'd640;
        end else begin
            if (i_cfg_we) begin
                r_wheelbase <= i_cfg_data;
            end
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---- sine/cosine of heading and steer ----
    logic signed [CRD_W-1:0] hs, hc, ss, sc;

    kbd_cordic #(.STEPS(CORDIC_STEPS)) u_head (
        .i_clk (i_clk),
        .i_en  (en[CE:0]),
        .i_ang (i_heading_angle),
        .o_sin (hs),
        .o_cos (hc)
    );

    kbd_cordic #(.STEPS(CORDIC_STEPS)) u_steer (
        .i_clk (i_clk),
        .i_en  (en[CE:0]),
        .i_ang (16'(i_steer_angle)),
        .o_sin (ss),
        .o_cos (sc)
    );

    // sideband alongside the CORDIC stages
    t_side_a r_sa [0:M1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sa[0] <= '{speed: i_speed, accel: i_accel_cmd, srate: i_steer_rate_cmd};
        end
    end

    for (genvar k = 1; k <= M1; k++) begin : g_sa
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // ---- M1: products ----
    logic signed [PRD_W-1:0] r_p_ss, r_p_hc, r_p_hs;
    logic signed [DPR_W-1:0] r_p_den;

    always_ff @(posedge i_clk) begin
        if (en[M1]) begin
            r_p_ss  <= PRD_W'(r_sa[CE].speed) * PRD_W'(ss);
            r_p_hc  <= PRD_W'(r_sa[CE].speed) * PRD_W'(hc);
            r_p_hs  <= PRD_W'(r_sa[CE].speed) * PRD_W'(hs);
            r_p_den <= DPR_W'($signed({1'b0, r_wheelbase})) * DPR_W'(sc);
        end
    end

    // ---- M2: round the rates, form dividend and divisor magnitudes ----
    logic [PRD_W-1:0]  nabs;
    logic [DPR_W-1:0]  dabs;
    logic [NUM_W-1:0]  n_num, r_num;
    logic [DEN_W-1:0]  n_den, r_den;
    t_side_b           n_sb;
    t_side_b           r_sb [M2:DL];

    always_comb begin
        nabs  = r_p_ss[PRD_W-1] ? PRD_W'(-r_p_ss) : PRD_W'(r_p_ss);
        dabs  = r_p_den[DPR_W-1] ? DPR_W'(-r_p_den) : DPR_W'(r_p_den);
        // dividend 2*|v*s*4096| + d, divisor 2*d: rounds half away from zero
        n_num = (NUM_W'(nabs) << 13) + NUM_W'(dabs);
        n_den = DEN_W'(dabs) << 1;
        n_sb.x_rate = rate_round(r_p_hc);
        n_sb.y_rate = rate_round(r_p_hs);
        n_sb.accel  = r_sa[M1].accel;
        n_sb.srate  = r_sa[M1].srate;
        n_sb.nneg   = r_p_ss[PRD_W-1];
        n_sb.qneg   = r_p_ss[PRD_W-1] != r_p_den[DPR_W-1];
        n_sb.nzero  = r_p_ss == '0;
        n_sb.dzero  = r_p_den == '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[M2]) begin
            r_num    <= n_num;
            r_den    <= n_den;
            r_sb[M2] <= n_sb;
        end
    end

    for (genvar k = D0; k <= DL; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---- divider ----
    logic [QUO_W-1:0] quot;
    logic             ovf;

    kbd_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[DL:D0]),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_quot (quot),
        .o_ovf  (ovf)
    );

    // ---- final stage: yaw clamp and output register ----
    logic signed [23:0] n_yaw;
    logic               n_sat;
    logic [QUO_W-1:0]   qlim;

    always_comb begin
        qlim  = r_sb[DL].qneg ? Q_LIM_NEG : Q_LIM_POS;
        n_sat = 1'b0;
        if (r_sb[DL].nzero) begin
            n_yaw = '0;
        end else if (r_sb[DL].dzero) begin
            n_sat = 1'b1;
            n_yaw = r_sb[DL].nneg ? YAW_MIN : YAW_MAX;
        end else if (ovf || quot > qlim) begin
            n_sat = 1'b1;
            n_yaw = r_sb[DL].qneg ? YAW_MIN : YAW_MAX;
        end else begin
            n_yaw = r_sb[DL].qneg ? 24'(-quot) : quot[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            o_x_rate     <= r_sb[DL].x_rate;
            o_y_rate     <= r_sb[DL].y_rate;
            o_speed_rate <= r_sb[DL].accel;
            o_steer_rate <= r_sb[DL].srate;
            o_yaw_rate   <= n_yaw;
            o_saturated  <= n_sat;
        end
    end

    assign o_valid = r_v[NS-1];

    // ---- assertions ----
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_yaw_rate == YAW_MAX || o_yaw_rate == YAW_MIN))
        else $error("saturated flag without a clipped yaw rate");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted transaction not captured in first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the kinematic bicycle derivative core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import kbd_pkg::*;

    localparam int STEPS     = 16;
    localparam int LATENCY   = STEPS + 31;
    localparam int CYCLE_CAP = 600000;

    // arctangent table, Q.24, one entry per CORDIC iteration
    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };
    localparam longint Q24_HALF_PI = 26353589;
    localparam longint Q24_PI      = 52707179;
    localparam longint Q30_GAIN    = 652032874;

    // one vehicle state plus control pair
    typedef struct packed {
        logic signed [15:0] head;
        logic signed [15:0] spd;
        logic signed [14:0] steer;
        logic signed [15:0] acc;
        logic signed [15:0] srt;
    } state_ctl_t;

    // one derivative transaction
    typedef struct packed {
        logic signed [15:0] xr;
        logic signed [15:0] yr;
        logic signed [23:0] yaw;
        logic signed [15:0] sr;
        logic signed [15:0] st;
        logic               sat;
    } deriv_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [12:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_heading_angle = '0;
    logic signed [15:0] i_speed = '0;
    logic signed [14:0] i_steer_angle = '0;
    logic signed [15:0] i_accel_cmd = '0;
    logic signed [15:0] i_steer_rate_cmd = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_x_rate;
    logic signed [15:0] o_y_rate;
    logic signed [23:0] o_yaw_rate;
    logic signed [15:0] o_speed_rate;
    logic signed [15:0] o_steer_rate;
    logic               o_saturated;

    kinematic_bicycle_derivative_core #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_heading_angle (i_heading_angle),
        .i_speed         (i_speed),
        .i_steer_angle   (i_steer_angle),
        .i_accel_cmd     (i_accel_cmd),
        .i_steer_rate_cmd(i_steer_rate_cmd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_x_rate        (o_x_rate),
        .o_y_rate        (o_y_rate),
        .o_yaw_rate      (o_yaw_rate),
        .o_speed_rate    (o_speed_rate),
        .o_steer_rate    (o_steer_rate),
        .o_saturated     (o_saturated)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bench state
    state_ctl_t pending_q[$];     // items waiting for the driver
    deriv_t     deriv_due[$];     // predicted derivatives, oldest first
    state_ctl_t on_bus;           // payload currently offered
    logic [12:0] wheelbase_mdl = 13'd640;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_req = 0;            // bumped to request a long receiver hold-off
    int stall_seen = 0;
    int stall_left = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_sat = 0;
    int n_bad = 0;
    int n_cycles = 0;

    // rotation-mode CORDIC, folded by pi outside +/- pi/2
    function automatic void cordic_sincos(input longint ang_q13, output longint s_q30,
                                          output longint c_q30);
        longint z, x, y, xs, ys;
        bit     flip;
        z = ang_q13 * 2048;
        x = Q30_GAIN;
        y = 0;
        flip = 1'b0;
        if (z > Q24_HALF_PI) begin
            z -= Q24_PI;
            flip = 1'b1;
        end else if (z < -Q24_HALF_PI) begin
            z += Q24_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_Q24[i];
            end else begin
                x += ys; y -= xs; z += ATAN_Q24[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s_q30 = y;
        c_q30 = x;
    endfunction

    // speed times trig term, round half up, clamp to 16 bits (no flag)
    function automatic logic signed [15:0] scale_rate(input longint v, input longint f);
        longint r;
        r = (v * f + (longint'(1) <<< 29)) >>> 30;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic deriv_t bicycle_deriv(input state_ctl_t a, input logic [12:0] wb);
        deriv_t d;
        longint hs, hc, ss, sc, v, num, den, yaw;
        bit [63:0] nmag, dmag, q;
        bit qneg, sat;
        v = a.spd;
        cordic_sincos(longint'(a.head), hs, hc);
        cordic_sincos(longint'(a.steer), ss, sc);
        num = v * ss * 4096;
        den = longint'(wb) * sc;
        qneg = (num < 0) != (den < 0);
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        sat = 1'b0;
        if (nmag == 0) begin
            yaw = 0;
        end else if (dmag == 0) begin
            // zero divisor: limit with the numerator's sign
            yaw = (num < 0) ? -8388608 : 8388607;
            sat = 1'b1;
        end else begin
            q = (2 * nmag + dmag) / (2 * dmag);
            if (qneg) begin
                if (q > 8388608) begin q = 8388608; sat = 1'b1; end
                yaw = -longint'(q);
            end else begin
                if (q > 8388607) begin q = 8388607; sat = 1'b1; end
                yaw = longint'(q);
            end
        end
        d.xr  = scale_rate(v, hc);
        d.yr  = scale_rate(v, hs);
        d.yaw = 24'(yaw);
        d.sr  = a.acc;
        d.st  = a.srt;
        d.sat = sat;
        return d;
    endfunction

    // random item: mostly legal ranges, some full width, some near the steer pole
    function automatic state_ctl_t random_state();
        state_ctl_t a;
        int mode;
        mode = $urandom_range(9);
        a.head  = 16'($urandom_range(51472) - 25736);
        a.spd   = 16'($urandom);
        a.steer = 15'($urandom_range(24576) - 12288);
        a.acc   = 16'($urandom);
        a.srt   = 16'($urandom);
        case (mode)
            0: begin
                a.head  = 16'($urandom);
                a.steer = 15'($urandom);
            end
            1: a.steer = 15'(($urandom_range(1) ? 12868 : -12868) + $urandom_range(40) - 20);
            2: a.spd = 16'($urandom_range(512) - 256);
            3: a.spd = '0;
            default: ;
        endcase
        return a;
    endfunction

    function automatic state_ctl_t mk(input int h, input int s, input int st,
                                      input int ac, input int sr);
        state_ctl_t a;
        a.head = 16'(h); a.spd = 16'(s); a.steer = 15'(st); a.acc = 16'(ac); a.srt = 16'(sr);
        return a;
    endfunction

    // driver: offers queued items, holds payload until the transaction completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                deriv_due.push_back(bicycle_deriv(on_bus, wheelbase_mdl));
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_q.pop_front();
                    i_heading_angle  <= on_bus.head;
                    i_speed          <= on_bus.spd;
                    i_steer_angle    <= on_bus.steer;
                    i_accel_cmd      <= on_bus.acc;
                    i_steer_rate_cmd <= on_bus.srt;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, long hold-off on request, checks each transaction
    always @(posedge i_clk) begin
        deriv_t got, want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_x_rate, o_y_rate, o_yaw_rate, o_speed_rate, o_steer_rate,
                        o_saturated};
                n_recv++;
                if (deriv_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected transaction: x %0d y %0d yaw %0d",
                                 got.xr, got.yr, got.yaw);
                end else begin
                    want = deriv_due.pop_front();
                    if (want.sat) n_sat++;
                    if (got.xr !== want.xr || got.yr !== want.yr || got.yaw !== want.yaw ||
                        got.sr !== want.sr || got.st !== want.st || got.sat !== want.sat) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("mismatch #%0d: exp x %0d y %0d yaw %0d sr %0d st %0d sat %0b",
                                     n_bad, want.xr, want.yr, want.yaw, want.sr, want.st,
                                     want.sat);
                            $display("               got x %0d y %0d yaw %0d sr %0d st %0d sat %0b",
                                     got.xr, got.yr, got.yaw, got.sr, got.st, got.sat);
                        end
                    end
                end
            end
        end
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d still due", n_cycles, deriv_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sampled on the falling edge, clear of the clocked driver and monitor
    task automatic drain();
        while (pending_q.size() > 0 || i_valid || deriv_due.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_wheelbase(input logic [12:0] wb);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= wb;
        wheelbase_mdl = wb;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [12:0] wb_list [6];
        wb_list = '{13'd640, 13'd128, 13'd4096, 13'd8191, 13'd0, 13'd900};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, steer past the pole, folded headings, zero speed
        pending_q.push_back(mk(0, 256, 0, 0, 0));
        pending_q.push_back(mk(25736, 32767, 12288, 32767, 32767));
        pending_q.push_back(mk(-25736, -32768, -12288, -32768, -32768));
        pending_q.push_back(mk(32767, 32767, 16383, 1, -1));
        pending_q.push_back(mk(-32768, -32768, -16384, -1, 1));
        pending_q.push_back(mk(12868, 1000, 12868, 0, 0));
        pending_q.push_back(mk(-12868, -1000, -12868, 0, 0));
        pending_q.push_back(mk(12869, 5000, 12869, 0, 0));
        pending_q.push_back(mk(6434, 256, 6434, 100, 100));
        pending_q.push_back(mk(0, 0, 8000, 5, 5));
        pending_q.push_back(mk(0, 0, 0, 0, 0));
        pending_q.push_back(mk(20000, 32767, 13000, 0, 0));
        pending_q.push_back(mk(-20000, -32768, -13000, 0, 0));
        pending_q.push_back(mk(0, 32767, 12800, 0, 0));
        pending_q.push_back(mk(0, -32768, 12800, 0, 0));
        pending_q.push_back(mk(25735, -1, -1, 21845, -21846));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_wheelbase(wb_list[ph] == 13'd900 ? 13'($urandom_range(128, 4096))
                                                   : wb_list[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int k = 0; k < 80; k++) pending_q.push_back(random_state());
            if (ph == 0) stall_req++;   // receiver holds off while the sender keeps going
            // sender pauses here until every result is back
            while (pending_q.size() > 0 || i_valid || deriv_due.size() > 0)
                @(negedge i_clk);
            for (int k = 0; k < 75; k++) pending_q.push_back(random_state());
            drain();
        end

        $display("covered %0d transactions over six wheelbase settings incl. 0 and 8191,",
                 n_sent);
        $display("with %0d saturated yaw rates and mixed idle/back-pressure phases", n_sat);
        if (n_bad == 0 && deriv_due.size() == 0 && n_recv == n_sent) begin
            $display("end of test: clean");
        end else begin
            $display("%0d errors, %0d left due", n_bad, deriv_due.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/kbd_pkg.sv
sv/kbd_cordic.sv
sv/kbd_div.sv
sv/kinematic_bicycle_derivative_core.sv
bench/tb_top.sv
